>>> rtl/core/free_list_page_allocator_core_assert.svh
// assertion macros for the free list page allocator core
// expects signals clk and rst in the scope of each use
`ifndef FREE_LIST_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define FREE_LIST_PAGE_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FLPA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FLPA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/flpa_pkg.sv
// shared constants, codes and types of the free list page allocator
// no dependencies
package flpa_pkg;

  localparam int MAX_PAGES = 1024;
  localparam int IDX_W     = $clog2(MAX_PAGES);
  localparam int LINK_W    = $clog2(MAX_PAGES + 1);
  localparam int PAGE_W    = 16;
  localparam int PCOUNT_W  = 11;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // item modes
  localparam logic [MODE_W-1:0] MODE_INIT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_PAGE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = 1'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_PAGE_ZERO = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic walk_step;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              walk_done;
    logic              out_free;
  } dp_stat_t;

endpackage

>>> rtl/core/flpa_ctrl.sv
// controller state machine of the free list page allocator
// depends on flpa_pkg
module flpa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  flpa_pkg::dp_stat_t  stat,
  output flpa_pkg::ctrl_cmd_t cmd
);
  import flpa_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_stall      = 1'b1;
    unique case (state)
      S_IDLE: begin
        // no item is taken while reset is held
        in_stall = rst;
        if (in_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = S_FINISH;
        end
      end
      S_WALK: begin
        if (stat.walk_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_FINISH: begin
        // init items walk the link table before they finish
        if (stat.mode == MODE_INIT && !stat.walk_done) begin
          state_next = S_WALK;
        end else if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/flpa_dp.sv
// datapath of the free list page allocator: config registers, link memory,
// head and count registers, output register; depends on flpa_pkg
module flpa_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  flpa_pkg::ctrl_cmd_t                   cmd,
  output flpa_pkg::dp_stat_t                    stat,
  input  logic [flpa_pkg::MODE_W-1:0]           mode,
  input  logic [flpa_pkg::PAGE_W-1:0]           page_in,
  input  logic                                  cfg_we,
  input  logic [flpa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [flpa_pkg::CFG_W-1:0]            cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [flpa_pkg::PAGE_W-1:0]           page_out,
  output logic [flpa_pkg::STATUS_W-1:0]         status,
  output logic [flpa_pkg::PCOUNT_W-1:0]         free_pages
);
  import flpa_pkg::*;

  logic [PAGE_W-1:0]   cfg_first_page;
  logic [PCOUNT_W-1:0] cfg_page_count;
  logic [MODE_W-1:0]   item_mode;
  logic [PAGE_W-1:0]   item_page;
  logic [LINK_W-1:0]   head;
  logic [LINK_W-1:0]   head_next;
  logic [LINK_W-1:0]   free_total;
  logic [LINK_W-1:0]   free_total_next;
  logic [LINK_W-1:0]   walk_cnt;
  logic [LINK_W-1:0]   rd_data;
  logic [LINK_W-1:0]   mem [MAX_PAGES];

  logic [LINK_W-1:0]   eff_count;
  logic                head_empty;
  logic [LINK_W-1:0]   walk_next;
  logic [LINK_W-1:0]   walk_link;
  logic [PAGE_W-1:0]   page_diff;
  logic                in_range;
  logic [IDX_W-1:0]    free_idx;
  logic [PAGE_W-1:0]   alloc_page;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wa;
  logic [LINK_W-1:0]   mem_wd;
  logic [PAGE_W-1:0]   res_page;
  status_t             res_status;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_first_page <= '0;
      cfg_page_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_PAGE: cfg_first_page <= cfg_data[PAGE_W-1:0];
        REG_PAGE_COUNT: cfg_page_count <= cfg_data[PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture and walk counter
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode <= mode;
      item_page <= page_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_cnt <= '0;
    end else if (cmd.capture) begin
      walk_cnt <= '0;
    end else if (cmd.walk_step) begin
      walk_cnt <= walk_next;
    end
  end

  // derived values
  always_comb begin
    eff_count  = (32'(cfg_page_count) > MAX_PAGES) ? LINK_W'(MAX_PAGES)
                                                   : LINK_W'(cfg_page_count);
    head_empty = 32'(head) >= MAX_PAGES;
    walk_next  = walk_cnt + LINK_W'(1);
    walk_link  = (walk_next == eff_count) ? LINK_W'(MAX_PAGES) : walk_next;
    page_diff  = item_page - cfg_first_page;
    in_range   = (item_page >= cfg_first_page) && (32'(page_diff) < 32'(eff_count));
    free_idx   = page_diff[IDX_W-1:0];
    alloc_page = cfg_first_page + PAGE_W'(head);
  end

  // link writes of the init walk, and commit of the item's effect and result
  always_comb begin
    head_next       = head;
    free_total_next = free_total;
    res_page        = '0;
    res_status      = ST_OK;
    mem_we          = cmd.walk_step;
    mem_wa          = walk_cnt[IDX_W-1:0];
    mem_wd          = walk_link;
    if (cmd.commit) begin
      unique case (item_mode)
        MODE_INIT: begin
          head_next       = (eff_count == '0) ? LINK_W'(MAX_PAGES) : '0;
          free_total_next = eff_count;
        end
        MODE_ALLOC: begin
          if (head_empty) begin
            res_status = ST_NO_FREE;
          end else begin
            res_page        = alloc_page;
            head_next       = rd_data;
            free_total_next = (free_total == '0) ? '0 : free_total - LINK_W'(1);
          end
        end
        MODE_FREE: begin
          if (item_page == '0) begin
            res_status = ST_PAGE_ZERO;
          end else if (!in_range) begin
            res_status = ST_RANGE;
          end else begin
            mem_we          = 1'b1;
            mem_wa          = free_idx;
            mem_wd          = head;
            head_next       = LINK_W'(free_idx);
            free_total_next = (32'(free_total) >= MAX_PAGES) ? free_total
                                                             : free_total + LINK_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // link memory, read port follows the head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[head[IDX_W-1:0]];
  end

  // list head and free count
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= LINK_W'(MAX_PAGES);
      free_total <= '0;
    end else begin
      head       <= head_next;
      free_total <= free_total_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      page_out   <= res_page;
      status     <= res_status;
      free_pages <= PCOUNT_W'(free_total_next);
    end
  end

  // status to controller
  always_comb begin
    stat.mode      = item_mode;
    stat.walk_done = walk_cnt >= eff_count;
    stat.out_free  = !out_valid || !out_stall;
  end

endmodule

>>> rtl/core/free_list_page_allocator_core.sv
// allocate, free and unknown items are captured on accept and committed to the output register
// from the finish state once that register is free; no new item is accepted before the commit;
// init items first walk the link table, writing one link entry per cycle (no walk with a zero count)
// reset clears the list to empty, the free count and the config registers to zero;
// the link memory is not cleared and holds nothing valid until init or free writes it
module free_list_page_allocator_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [flpa_pkg::MODE_W-1:0]     mode,
  input  logic [flpa_pkg::PAGE_W-1:0]     page_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [flpa_pkg::PAGE_W-1:0]     page_out,
  output logic [flpa_pkg::STATUS_W-1:0]   status,
  output logic [flpa_pkg::PCOUNT_W-1:0]   free_pages,
  input  logic                            cfg_we,
  input  logic [flpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [flpa_pkg::CFG_W-1:0]      cfg_data
);
  import flpa_pkg::*;

`include "free_list_page_allocator_core_assert.svh"

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // controller
  flpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  flpa_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .mode       (mode),
    .page_in    (page_in),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .page_out   (page_out),
    .status     (status),
    .free_pages (free_pages)
  );

  // checks
  `FLPA_ASSERT_IMP(a_commit_slot_free, cmd.commit, !out_valid || !out_stall, "result overwritten")
  `FLPA_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid, "committed result not shown")
  `FLPA_ASSERT_IMP(a_count_bound, out_valid, 32'(free_pages) <= MAX_PAGES, "free count too large")
  `FLPA_ASSERT_IMP(a_fail_page_zero, out_valid && status != ST_OK, page_out == '0, "page on failure")

endmodule
